// ===== hw/rtl/pud_pkg.sv =====
package pud_pkg;

   // One raw character of the encoded string
   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   // One decoded character
   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
   } rsp_type;

   // Results caused by one request: byte_list[0] goes out first, the
   // last flag belongs to byte_list[count - 1] only
   typedef struct packed {
      logic [1:0]      count;
      logic [2:0][7:0] byte_list;
      logic            last;
   } cmd_type;

   typedef enum logic [1:0] {
      STAGE_IDLE = 2'd0,
      STAGE_PCT  = 2'd1,
      STAGE_HELD = 2'd2
   } stage_type;

endpackage

// ===== hw/rtl/pud_front.sv =====
module pud_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  pud_pkg::req_type req_item,
   output logic             cmd_push,
   output pud_pkg::cmd_type cmd
);

   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_SPACE   = 8'h20;

   pud_pkg::stage_type stage_ff, stage_in;
   logic [7:0]         held_ff, held_in;
   logic [7:0]         b;
   logic               last;

   function automatic logic is_hex(input logic [7:0] c);
      logic r;
      case (c) inside
         [8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]: r = 1'b1;
         default:                                     r = 1'b0;
      endcase
      return r;
   endfunction

   function automatic logic [3:0] hex_val(input logic [7:0] c);
      logic [3:0] r;
      case (c) inside
         [8'h30:8'h39]: r = c[3:0];
         [8'h41:8'h46],
         [8'h61:8'h66]: r = c[3:0] + 4'd9;
         default:       r = 4'd0;
      endcase
      return r;
   endfunction

   // Map '+' to a space, pass anything else
   function automatic logic [7:0] plain(input logic [7:0] c);
      return (c == CH_PLUS) ? CH_SPACE : c;
   endfunction

   assign b    = req_item.in_byte;
   assign last = req_item.in_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= pud_pkg::STAGE_IDLE;
      end else begin
         stage_ff <= stage_in;
      end
      held_ff <= held_in;
   end

   always_comb begin
      stage_in      = stage_ff;
      held_in       = held_ff;
      cmd.count     = 2'd0;
      cmd.byte_list = '0;
      cmd.last      = last;
      case (stage_ff)
         pud_pkg::STAGE_PCT: begin
            if (last) begin
               cmd.byte_list[0] = CH_PERCENT;
               cmd.byte_list[1] = plain(b);
               cmd.count        = 2'd2;
               stage_in         = pud_pkg::STAGE_IDLE;
            end else begin
               held_in  = b;
               stage_in = pud_pkg::STAGE_HELD;
            end
         end
         pud_pkg::STAGE_HELD: begin
            if (is_hex(held_ff) && is_hex(b)) begin
               cmd.byte_list[0] = {hex_val(held_ff), hex_val(b)};
               cmd.count        = 2'd1;
               stage_in         = pud_pkg::STAGE_IDLE;
            end else begin
               cmd.byte_list[0] = CH_PERCENT;
               if (held_ff == CH_PERCENT && !last) begin
                  // held '%' reopens the escape with this byte as follower
                  cmd.count = 2'd1;
                  held_in   = b;
               end else begin
                  cmd.byte_list[1] = plain(held_ff);
                  if (b == CH_PERCENT && !last) begin
                     cmd.count = 2'd2;
                     stage_in  = pud_pkg::STAGE_PCT;
                  end else begin
                     cmd.byte_list[2] = plain(b);
                     cmd.count        = 2'd3;
                     stage_in         = pud_pkg::STAGE_IDLE;
                  end
               end
            end
         end
         default: begin
            if (b == CH_PERCENT && !last) begin
               stage_in = pud_pkg::STAGE_PCT;
            end else begin
               cmd.byte_list[0] = plain(b);
               cmd.count        = 2'd1;
               stage_in         = pud_pkg::STAGE_IDLE;
            end
         end
      endcase
      if (!accept) begin
         stage_in = stage_ff;
         held_in  = held_ff;
      end
      cmd_push = accept && (cmd.count != 2'd0);
   end

endmodule

// ===== hw/rtl/pud_cmd_queue.sv =====
module pud_cmd_queue #(
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  pud_pkg::cmd_type push_cmd,
   input  logic             pop,
   output pud_pkg::cmd_type head,
   output logic             empty,
   output logic             full
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

   pud_pkg::cmd_type slot_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == FULL_CNT);
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== hw/rtl/pud_back.sv =====
module pud_back (
   input  logic             clock,
   input  logic             reset,
   input  pud_pkg::cmd_type head,
   input  logic             q_empty,
   output logic             q_pop,
   output pud_pkg::rsp_type rsp_item,
   output logic             rsp_empty,
   input  logic             rsp_pop
);

   logic             out_valid_ff, out_valid_in;
   pud_pkg::rsp_type out_ff, out_in;
   logic [1:0]       sub_ff, sub_in;
   logic             load;
   logic             final_sub;

   assign rsp_empty = !out_valid_ff;
   assign rsp_item  = out_ff;

   always_comb begin
      load         = !q_empty && (!out_valid_ff || rsp_pop);
      final_sub    = (sub_ff == head.count - 2'd1);
      q_pop        = load && final_sub;
      sub_in       = sub_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      if (load) begin
         out_in.out_byte = head.byte_list[sub_ff];
         out_in.out_last = head.last && final_sub;
         out_valid_in    = 1'b1;
         sub_in          = final_sub ? 2'd0 : sub_ff + 2'd1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         sub_ff       <= 2'd0;
      end else begin
         out_valid_ff <= out_valid_in;
         sub_ff       <= sub_in;
      end
      out_ff <= out_in;
   end

endmodule

// ===== hw/rtl/url_percent_decoder_unit.sv =====
// A decoded byte passes a command queue slot, then the output register, to reach rsp_item.
// Throughput: one request per cycle while req_full is low; one byte per cycle leaves the
// output register while rsp_pop drains it, the queue absorbing the up-to-three-byte bursts.
// Reset: synchronous, active high; clears escape state, command queue and output register.
module url_percent_decoder_unit #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  pud_pkg::req_type req_item,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output pud_pkg::rsp_type rsp_item
);

   // Front: classify each request against the escape state and turn it
   // into a command of zero to three output bytes.
   // Queue: hold commands so the front keeps taking one request a cycle
   // while the queue has room and the back works through a burst.
   // Back: serialise each command into single bytes behind an output
   // register, tagging only the final byte with the last flag.

   logic             accept;
   logic             cmd_push;
   pud_pkg::cmd_type cmd;
   pud_pkg::cmd_type head;
   logic             q_empty;
   logic             q_pop;

   // Accept whenever the queue has room; a request yielding no bytes
   // still advances the escape state.
   assign accept = req_push && !req_full;

   pud_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_item (req_item),
      .cmd_push (cmd_push),
      .cmd      (cmd)
   );

   pud_cmd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .push_cmd (cmd),
      .pop      (q_pop),
      .head     (head),
      .empty    (q_empty),
      .full     (req_full)
   );

   pud_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .rsp_item  (rsp_item),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop)
   );

`ifndef NO_ASSERTIONS
   // Output register must be clear straight after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result pending after reset");

   // A full queue implies the back has already loaded a result
   a_full_has_rsp: assert property (@(posedge clock) disable iff (reset)
      req_full |-> !rsp_empty)
      else $error("queue full with output register empty");

   // Never retire a command that is not there
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("command popped from empty queue");
`endif

endmodule
